// ----- rtl/swt_pkg.sv -----
// shared constants and types of the sleep wake-up table
`default_nettype none

package swt_pkg;

  // table geometry
  localparam int SLOTS        = 16;
  localparam int IDX_W        = $clog2(SLOTS);
  localparam int CNT_W        = $clog2(SLOTS + 1);

  // woken results one tick may give at most
  localparam int RESULT_LIMIT = 16;
  localparam int EMIT_W       = $clog2(RESULT_LIMIT + 1);

  // field widths
  localparam int TICK_W       = 63;
  localparam int TID_W        = 8;
  localparam int DUR_W        = 32;

  // queue between front and back
  localparam int QDEPTH       = 2;
  localparam int QPTR_W       = $clog2(QDEPTH);
  localparam int QCNT_W       = $clog2(QDEPTH + 1);

  // operation codes
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_SLEEP = 1'b1;

  // result kinds
  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_WOKEN  = 2'd1;
  localparam logic [1:0] KIND_NONE   = 2'd2;

  // sleep status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NONPOS = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  // classified word handed from front to back
  typedef struct packed {
    logic               is_sleep;
    logic               nonpos;
    logic [TID_W-1:0]   thread_id;
    logic [DUR_W-2:0]   dur;
  } swt_item_t;

  // one table entry
  typedef struct packed {
    logic [TICK_W-1:0]  wake;
    logic [TID_W-1:0]   tid;
  } swt_entry_t;

endpackage

`default_nettype wire

// ----- rtl/sleep_wakeup_table.sv -----
// top level of the sleep wake-up table
//
//  channel  dir  handshake             tdata / tuser / tlast
//  in_      in   in_tvalid/in_tready   tdata: thread_id, sleep_ticks; tuser: operation
//  out_     out  out_tvalid/out_tready tdata: status, woken_thread, now_tick;
//                                      tuser: result_kind; tlast: last
//
//  a sleep word is handled in the back end once it reaches the queue head and the
//  result register is free; a tick word is handled as one start step, one step per
//  stored entry through the single table read port, and one closing step
//  reset clears the tick count, entry count and queue; the table is not cleared
//  a stalled out_tready holds the scan while the front queue takes words until full
`default_nettype none

module sleep_wakeup_table
  import swt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,    // [7:0] thread_id, [39:8] sleep_ticks
  input  logic        in_tuser,    // [0] operation
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,   // [1:0] status, [9:2] woken_thread,
                                   // [72:10] now_tick, [79:73] zero
  output logic [1:0]  out_tuser,   // [1:0] result_kind
  output logic        out_tlast    // last word caused by one input word
);

  // words between front and back
  logic              q_valid;
  swt_item_t         q_item;
  logic              q_pop;

  logic [1:0]        res_status;
  logic [TID_W-1:0]  res_thread;
  logic [TICK_W-1:0] res_now;

  // front: accept and classify into the short queue
  swt_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_tvalid),
    .in_ready       (in_tready),
    .in_op          (in_tuser),
    .in_thread_id   (in_tdata[7:0]),
    .in_sleep_ticks (in_tdata[39:8]),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop)
  );

  // back: table, scan and result register
  swt_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_kind   (out_tuser),
    .out_status (res_status),
    .out_thread (res_thread),
    .out_now    (res_now),
    .out_last   (out_tlast)
  );

  // pack the result word, padding to whole bytes
  assign out_tdata = {7'b0, res_now, res_thread, res_status};

endmodule

`default_nettype wire

// ----- rtl/swt_front.sv -----
// front end: accepts input words, classifies them and queues them for the back end
`default_nettype none

module swt_front
  import swt_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_op,
  input  logic [TID_W-1:0]        in_thread_id,
  input  logic signed [DUR_W-1:0] in_sleep_ticks,
  output logic                    q_valid,
  output swt_item_t               q_item,
  input  logic                    q_pop
);

  swt_item_t             q_mem_r [QDEPTH];
  logic [QPTR_W-1:0]     wr_ptr_r;
  logic [QPTR_W-1:0]     rd_ptr_r;
  logic [QCNT_W-1:0]     cnt_r;
  logic [QCNT_W-1:0]     cnt_nxt;
  logic                  push;
  logic                  pop;
  swt_item_t             item_in;

  assign in_ready = (cnt_r != QCNT_W'(QDEPTH));
  assign q_valid  = (cnt_r != '0);
  assign q_item   = q_mem_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;

  // length of zero or a negative one is marked here
  always_comb begin
    item_in.is_sleep  = (in_op == OP_SLEEP);
    item_in.nonpos    = in_sleep_ticks[DUR_W-1] || (in_sleep_ticks == '0);
    item_in.thread_id = in_thread_id;
    item_in.dur       = in_sleep_ticks[DUR_W-2:0];
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= item_in;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/swt_back.sv -----
// back end: tick counter, entry table, compacting scan and result register
`default_nettype none

module swt_back
  import swt_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  swt_item_t         q_item,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_kind,
  output logic [1:0]        out_status,
  output logic [TID_W-1:0]  out_thread,
  output logic [TICK_W-1:0] out_now,
  output logic              out_last
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic               state_r, state_nxt;
  logic [TICK_W-1:0]  tick_r, tick_nxt;
  logic [CNT_W-1:0]   used_r, used_nxt;
  logic [CNT_W-1:0]   scan_i_r, scan_nxt;
  logic [CNT_W-1:0]   keep_r, keep_nxt;
  logic [CNT_W-1:0]   scan_inc;
  logic [EMIT_W-1:0]  emit_cnt_r, emit_cnt_nxt;
  logic               pend_v_r, pend_v_nxt;
  logic [TID_W-1:0]   pend_tid_r, pend_tid_nxt;

  swt_entry_t         mem_r [SLOTS];
  swt_entry_t         rd_entry_r;
  swt_entry_t         mem_wdata;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  logic [IDX_W-1:0]   raddr;

  logic               out_valid_r;
  logic [1:0]         out_kind_r;
  logic [1:0]         out_status_r;
  logic [TID_W-1:0]   out_thread_r;
  logic [TICK_W-1:0]  out_now_r;
  logic               out_last_r;

  logic               out_free;
  logic               due;
  logic               emit;
  logic [1:0]         e_kind;
  logic [1:0]         e_status;
  logic [TID_W-1:0]   e_thread;
  logic               e_last;

  assign out_free = !out_valid_r || out_ready;
  assign scan_inc = scan_i_r + 1'b1;
  assign due      = (rd_entry_r.wake <= tick_r) &&
                    (emit_cnt_r < EMIT_W'(RESULT_LIMIT));

  always_comb begin
    q_pop        = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = used_r[IDX_W-1:0];
    mem_wdata    = rd_entry_r;
    raddr        = scan_i_r[IDX_W-1:0];
    emit         = 1'b0;
    e_kind       = KIND_STATUS;
    e_status     = ST_OK;
    e_thread     = '0;
    e_last       = 1'b1;
    state_nxt    = state_r;
    tick_nxt     = tick_r;
    used_nxt     = used_r;
    scan_nxt     = scan_i_r;
    keep_nxt     = keep_r;
    emit_cnt_nxt = emit_cnt_r;
    pend_v_nxt   = pend_v_r;
    pend_tid_nxt = pend_tid_r;

    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          if (q_item.is_sleep) begin
            if (out_free) begin
              q_pop = 1'b1;
              emit  = 1'b1;
              if (q_item.nonpos) begin
                e_status = ST_NONPOS;
              end else if (used_r == CNT_W'(SLOTS)) begin
                e_status = ST_FULL;
              end else begin
                e_status       = ST_OK;
                mem_we         = 1'b1;
                mem_waddr      = used_r[IDX_W-1:0];
                mem_wdata.wake = tick_r + TICK_W'(q_item.dur);
                mem_wdata.tid  = q_item.thread_id;
                used_nxt       = used_r + 1'b1;
              end
            end
          end else begin
            // tick: bump the count and start the scan at entry zero
            q_pop        = 1'b1;
            tick_nxt     = tick_r + 1'b1;
            raddr        = '0;
            scan_nxt     = '0;
            keep_nxt     = '0;
            emit_cnt_nxt = '0;
            pend_v_nxt   = 1'b0;
            state_nxt    = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (scan_i_r == used_r) begin
          // closing result carries the final flag
          if (out_free) begin
            emit       = 1'b1;
            e_last     = 1'b1;
            if (pend_v_r) begin
              e_kind   = KIND_WOKEN;
              e_thread = pend_tid_r;
            end else begin
              e_kind   = KIND_NONE;
            end
            used_nxt   = keep_r;
            pend_v_nxt = 1'b0;
            state_nxt  = S_IDLE;
          end
        end else if (due) begin
          // a due entry is held back one step so the final flag is known
          if (!pend_v_r || out_free) begin
            if (pend_v_r) begin
              emit     = 1'b1;
              e_kind   = KIND_WOKEN;
              e_thread = pend_tid_r;
              e_last   = 1'b0;
            end
            pend_v_nxt   = 1'b1;
            pend_tid_nxt = rd_entry_r.tid;
            emit_cnt_nxt = emit_cnt_r + 1'b1;
            scan_nxt     = scan_inc;
            raddr        = scan_inc[IDX_W-1:0];
          end
        end else begin
          // entry stays: close it up at the keep position
          mem_we    = 1'b1;
          mem_waddr = keep_r[IDX_W-1:0];
          mem_wdata = rd_entry_r;
          keep_nxt  = keep_r + 1'b1;
          scan_nxt  = scan_inc;
          raddr     = scan_inc[IDX_W-1:0];
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      tick_r     <= '0;
      used_r     <= '0;
      scan_i_r   <= '0;
      keep_r     <= '0;
      emit_cnt_r <= '0;
      pend_v_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      tick_r     <= tick_nxt;
      used_r     <= used_nxt;
      scan_i_r   <= scan_nxt;
      keep_r     <= keep_nxt;
      emit_cnt_r <= emit_cnt_nxt;
      pend_v_r   <= pend_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_tid_r <= pend_tid_nxt;
  end

  // entry table, one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[mem_waddr] <= mem_wdata;
    end
    rd_entry_r <= mem_r[raddr];
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_kind_r   <= e_kind;
      out_status_r <= e_status;
      out_thread_r <= e_thread;
      out_now_r    <= tick_r;
      out_last_r   <= e_last;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_kind   = out_kind_r;
  assign out_status = out_status_r;
  assign out_thread = out_thread_r;
  assign out_now    = out_now_r;
  assign out_last   = out_last_r;

`ifndef SYNTHESIS
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CNT_W'(SLOTS))
    else $error("entry count beyond table size");

  a_keep_behind: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (keep_r <= scan_i_r) && (scan_i_r <= used_r))
    else $error("compaction index ahead of scan index");

  a_none_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_kind_r == KIND_NONE)) |-> out_last_r)
    else $error("none-woken result without final flag");

  a_sleep_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && q_pop && q_item.is_sleep && mem_we)
      |=> (used_r == $past(used_r) + 1'b1))
    else $error("accepted sleep did not add an entry");

  a_scan_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && scan_i_r == used_r && out_valid_r && !out_ready)
      |=> (state_r == S_SCAN))
    else $error("scan closed while result register blocked");
`endif

endmodule

`default_nettype wire
